FILE: rtl/core/sar_pkg.sv
// Shared command codes, mirroring codes and register-set type for the scroll address unit.
`default_nettype none

package sar_pkg;

  localparam int unsigned ADDR_W = 15;
  localparam int unsigned CMD_W = 4;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned INDEX_W = 12;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CTRL_WRITE   = 4'd0;
  localparam logic [CMD_W-1:0] CMD_SCROLL_WRITE = 4'd1;
  localparam logic [CMD_W-1:0] CMD_ADDR_WRITE   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_STATUS_READ  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DATA_ACCESS  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_COARSE_X_INC = 4'd5;
  localparam logic [CMD_W-1:0] CMD_Y_INC        = 4'd6;
  localparam logic [CMD_W-1:0] CMD_COPY_X       = 4'd7;
  localparam logic [CMD_W-1:0] CMD_COPY_Y       = 4'd8;

  // Nametable mirroring codes.
  localparam logic [MODE_W-1:0] MIRROR_HORIZONTAL = 3'd0;
  localparam logic [MODE_W-1:0] MIRROR_VERTICAL   = 3'd1;
  localparam logic [MODE_W-1:0] MIRROR_SINGLE_LO  = 3'd2;
  localparam logic [MODE_W-1:0] MIRROR_SINGLE_HI  = 3'd3;
  localparam logic [MODE_W-1:0] MIRROR_FOUR       = 3'd4;

  // Bits copied from temp to current by the horizontal and vertical copies.
  localparam logic [ADDR_W-1:0] HORIZ_BITS = 15'h041F;
  localparam logic [ADDR_W-1:0] VERT_BITS  = 15'h7BE0;

  localparam logic [4:0] COARSE_Y_LAST_ROW = 5'd29;
  localparam logic [4:0] COARSE_Y_MAX      = 5'd31;

  typedef struct packed {
    logic [ADDR_W-1:0] vram;
    logic [ADDR_W-1:0] temp;
    logic [2:0]        fine_x;
    logic              second_write;
    logic              step_by_row;
  } scroll_regs_t;

endpackage

`default_nettype wire

FILE: rtl/core/sar_step.sv
// Next-state logic of the scroll registers for one command.
`default_nettype none

module sar_step (
  input  sar_pkg::scroll_regs_t           cur,
  input  logic [sar_pkg::CMD_W-1:0]       command,
  input  logic [sar_pkg::DATA_W-1:0]      write_data,
  output sar_pkg::scroll_regs_t           nxt
);
  import sar_pkg::*;

  logic [4:0] cur_row;

  always_comb begin
    nxt = cur;
    cur_row = cur.vram[9:5];
    unique case (command)
      CMD_CTRL_WRITE: begin
        nxt.step_by_row = write_data[2];
        nxt.temp[11:10] = write_data[1:0];
      end
      CMD_SCROLL_WRITE: begin
        if (!cur.second_write) begin
          nxt.temp[4:0] = write_data[7:3];
          nxt.fine_x = write_data[2:0];
        end else begin
          nxt.temp[14:12] = write_data[2:0];
          nxt.temp[9:5] = write_data[7:3];
        end
        nxt.second_write = ~cur.second_write;
      end
      CMD_ADDR_WRITE: begin
        if (!cur.second_write) begin
          nxt.temp[14] = 1'b0;
          nxt.temp[13:8] = write_data[5:0];
        end else begin
          nxt.temp[7:0] = write_data;
          nxt.vram = {cur.temp[14:8], write_data};
        end
        nxt.second_write = ~cur.second_write;
      end
      CMD_STATUS_READ: begin
        nxt.second_write = 1'b0;
      end
      CMD_DATA_ACCESS: begin
        nxt.vram = cur.vram + (cur.step_by_row ? 15'd32 : 15'd1);
      end
      CMD_COARSE_X_INC: begin
        // Wrapping past the last column switches the horizontal nametable.
        if (cur.vram[4:0] == 5'd31) begin
          nxt.vram[4:0] = 5'd0;
          nxt.vram[10] = ~cur.vram[10];
        end else begin
          nxt.vram[4:0] = cur.vram[4:0] + 5'd1;
        end
      end
      CMD_Y_INC: begin
        if (cur.vram[14:12] != 3'd7) begin
          nxt.vram[14:12] = cur.vram[14:12] + 3'd1;
        end else begin
          nxt.vram[14:12] = 3'd0;
          // Leaving the last visible row switches the vertical nametable;
          // the last row of the attribute area wraps without switching.
          if (cur_row == COARSE_Y_LAST_ROW) begin
            nxt.vram[9:5] = 5'd0;
            nxt.vram[11] = ~cur.vram[11];
          end else if (cur_row == COARSE_Y_MAX) begin
            nxt.vram[9:5] = 5'd0;
          end else begin
            nxt.vram[9:5] = cur_row + 5'd1;
          end
        end
      end
      CMD_COPY_X: begin
        nxt.vram = (cur.vram & VERT_BITS) | (cur.temp & HORIZ_BITS);
      end
      CMD_COPY_Y: begin
        nxt.vram = (cur.vram & HORIZ_BITS) | (cur.temp & VERT_BITS);
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/sar_fetch.sv
// Mirrored tile and attribute fetch indexes derived from the current address.
`default_nettype none

module sar_fetch (
  input  logic [sar_pkg::INDEX_W-1:0] vram,
  input  logic [sar_pkg::MODE_W-1:0]  mirroring_mode,
  output logic [sar_pkg::INDEX_W-1:0] tile_idx,
  output logic [sar_pkg::INDEX_W-1:0] attr_index,
  output logic [2:0]                  shift
);
  import sar_pkg::*;

  logic [INDEX_W-1:0] tile_off;
  logic [INDEX_W-1:0] attr_off;

  function automatic logic [INDEX_W-1:0] mirror(input logic [INDEX_W-1:0] off,
                                                input logic [MODE_W-1:0] mode);
    logic [INDEX_W-1:0] res;
    begin
      unique case (mode)
        MIRROR_HORIZONTAL: res = {1'b0, off[11], off[9:0]};
        MIRROR_VERTICAL:   res = {1'b0, off[10], off[9:0]};
        MIRROR_SINGLE_LO:  res = {2'b00, off[9:0]};
        MIRROR_SINGLE_HI:  res = {2'b01, off[9:0]};
        default:           res = off;
      endcase
      return res;
    end
  endfunction

  assign tile_off = vram[11:0];
  // Attribute byte sits at the end of the nametable, one byte per 4x4 tiles.
  assign attr_off = {vram[11:10], 4'b1111, vram[9:7], vram[4:2]};

  assign tile_idx = mirror(tile_off, mirroring_mode);
  assign attr_index = mirror(attr_off, mirroring_mode);
  assign shift = {vram[6], vram[1], 1'b0};

endmodule

`default_nettype wire

FILE: rtl/core/scroll_address_register_unit.sv
// Top level of the scroll and video-address register unit.
`default_nettype none

// Scroll address register unit. Each accepted command is captured in an input
// register and applied, as it leaves that register, to the current address,
// the temporary address, the fine X scroll, the write toggle and the
// increment-by-32 bit; the result register then holds both addresses, the
// scroll state and the mirrored tile and attribute fetch indexes computed from
// the updated current address. One command is accepted every cycle unless both
// stages are full; the only loop is the update of the register set. The input
// register keeps taking commands while a result waits, stalling only when both
// stages are full. The mirroring mode is written through cfg_write_en and
// cfg_write_data and should change only while no command is in flight; codes
// above four-screen behave as four-screen.
module scroll_address_register_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [sar_pkg::MODE_W-1:0]    cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sar_pkg::CMD_W-1:0]     command,
  input  logic [sar_pkg::DATA_W-1:0]    write_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sar_pkg::ADDR_W-1:0]    vram_addr,
  output logic [sar_pkg::ADDR_W-1:0]    temp_addr,
  output logic [2:0]                    fine_x,
  output logic                          toggle_state,
  output logic [sar_pkg::INDEX_W-1:0]   tile_fetch_index,
  output logic [sar_pkg::INDEX_W-1:0]   attr_fetch_index,
  output logic [2:0]                    attr_shift
);
  import sar_pkg::*;

  logic [MODE_W-1:0]  mirroring_mode;

  // Input stage.
  logic               s1_valid;
  logic [CMD_W-1:0]   s1_command;
  logic [DATA_W-1:0]  s1_write_data;
  logic               advance;

  // Architectural register set and its next value.
  scroll_regs_t       regs;
  scroll_regs_t       regs_next;

  logic [INDEX_W-1:0] tile_idx_next;
  logic [INDEX_W-1:0] attr_index_next;
  logic [2:0]         shift_next;

  // The input stage moves on whenever the result register is empty or its
  // current result is being transferred out in this cycle.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      mirroring_mode <= MIRROR_HORIZONTAL;
    end else if (cfg_write_en) begin
      mirroring_mode <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_command <= command;
      s1_write_data <= write_data;
    end
  end

  sar_step u_step (
    .cur        (regs),
    .command    (s1_command),
    .write_data (s1_write_data),
    .nxt        (regs_next)
  );

  // Only the nametable part of the address feeds the fetch indexes.
  sar_fetch u_fetch (
    .vram           (regs_next.vram[INDEX_W-1:0]),
    .mirroring_mode (mirroring_mode),
    .tile_idx       (tile_idx_next),
    .attr_index     (attr_index_next),
    .shift          (shift_next)
  );

  // The register set changes exactly once per command, as it leaves the
  // input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (advance) begin
      regs <= regs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      vram_addr        <= regs_next.vram;
      temp_addr        <= regs_next.temp;
      fine_x           <= regs_next.fine_x;
      toggle_state     <= regs_next.second_write;
      tile_fetch_index <= tile_idx_next;
      attr_fetch_index <= attr_index_next;
      attr_shift       <= shift_next;
    end
  end

  // A status read always leaves the toggle cleared.
  a_status_clears_toggle: assert property (@(posedge clk) disable iff (rst)
    advance && s1_command == CMD_STATUS_READ |=> !regs.second_write)
    else $error("status read did not clear the write toggle");

  // The second address write copies the completed temp address to current.
  a_addr_second_write: assert property (@(posedge clk) disable iff (rst)
    advance && s1_command == CMD_ADDR_WRITE && regs.second_write
      |=> regs.vram == regs.temp)
    else $error("second address write did not load the current address");

  // Commands that are not register writes never touch the temp address.
  a_temp_kept: assert property (@(posedge clk) disable iff (rst)
    advance && s1_command != CMD_CTRL_WRITE && s1_command != CMD_SCROLL_WRITE
      && s1_command != CMD_ADDR_WRITE |=> $stable(regs.temp))
    else $error("temp address changed on a non-write command");

  // The result register mirrors the register set while it holds a result.
  a_result_matches_regs: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> vram_addr == regs.vram && temp_addr == regs.temp
      && toggle_state == regs.second_write)
    else $error("result register out of step with the register set");

  // Stalling the input only happens with both stages full.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
